@@ sv/bsre_pkg.sv @@
// ---------------------------------------------------------------------------
// bsre_pkg
// Shared types, codes and helpers for the bitmap shape raster engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsre_pkg;

    // Bitmap geometry
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int DIM_W    = 7;

    // Command codes
    localparam logic [1:0] FUNC_LINE     = 2'd0;
    localparam logic [1:0] FUNC_SQUARE   = 2'd1;
    localparam logic [1:0] FUNC_TRIANGLE = 2'd2;
    localparam logic [1:0] FUNC_READ     = 2'd3;

    // Triangle opening codes
    localparam logic [1:0] DIR_RU = 2'd0;
    localparam logic [1:0] DIR_RD = 2'd1;
    localparam logic [1:0] DIR_LD = 2'd2;
    localparam logic [1:0] DIR_LU = 2'd3;

    // Register indexes (byte address bit 2)
    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] PANEL_RESET = DIM_W'(64);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } bsre_state_t;

    // Clamp a panel size register to 1..maxv
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Ones in columns lo..hi inclusive (lo <= hi)
    function automatic logic [MAX_COLS-1:0] span_mask(input logic [COL_W-1:0] lo,
                                                      input logic [COL_W-1:0] hi);
        logic [COL_W-1:0] top_gap;
        top_gap = COL_W'(MAX_COLS - 1) - hi;
        return ({MAX_COLS{1'b1}} << lo) & ({MAX_COLS{1'b1}} >> top_gap);
    endfunction

endpackage

`default_nettype wire

@@ sv/bitmap_shape_raster_engine_unit.sv @@
// ---------------------------------------------------------------------------
// bitmap_shape_raster_engine_unit
// 64x64 one-bit bitmap with line, square and triangle fill commands and
// a row read command. Shapes are drawn one bitmap row per cycle through a
// masked read-modify-write on a synchronous 1-read 1-write row memory.
// ---------------------------------------------------------------------------
// Flow: a shape command steps through PREP, RUN, DRAIN and DONE before its
//   result word is registered; a row read goes through PREP, READ and DONE,
//   and a rejected command through PREP and DONE.
// A new command is accepted only in IDLE, once the previous result word
//   has been loaded into the output register.
// Reset: synchronous, active low; the bitmap reads as cleared right after
//   reset through per-row valid flags, panel size returns to 64 x 64.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_shape_raster_engine_unit
    import bsre_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Command channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_func,
    input  wire logic signed [7:0]   s_point_a_col,
    input  wire logic signed [7:0]   s_point_a_row,
    input  wire logic signed [7:0]   s_point_b_col,
    input  wire logic signed [7:0]   s_point_b_row,
    input  wire logic [6:0]          s_side_length,
    input  wire logic [1:0]          s_direction,
    // Result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_out_of_range,
    output logic [MAX_COLS-1:0]      m_row_bits,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    bsre_state_t state_reg, state_next;

    logic [DIM_W-1:0] panel_width_reg, panel_height_reg;
    logic [DIM_W-1:0] w_eff, h_eff;

    // Captured command word
    logic [1:0]       func_reg;
    logic [7:0]       ac_reg, ar_reg, bc_reg, br_reg;
    logic [6:0]       side_reg;
    logic [1:0]       dir_reg;

    // Run parameters
    logic [COL_W-1:0]  col_a_reg, col_b_reg, dc_reg, e_reg;
    logic              col_neg_reg, tri_right_reg, row_down_reg;
    logic [ROW_AW-1:0] row_start_reg, last_k_reg, k_reg;

    // Pending result
    logic                res_oor_reg;
    logic [MAX_COLS-1:0] res_bits_reg;

    // Output register
    logic                m_valid_reg, m_oor_reg;
    logic [MAX_COLS-1:0] m_bits_reg;

    // Row memory and write-back stage
    logic [MAX_COLS-1:0] pixel_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic                wr_en_reg;
    logic [ROW_AW-1:0]   wr_row_reg;
    logic [MAX_COLS-1:0] wr_mask_reg;
    logic [MAX_COLS-1:0] rd_row_data;

    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic                load_out;
    logic                cfg_wr;

    // Range check terms
    logic signed [9:0] ac_s, ar_s, bc_s, br_s, w_s, h_s, side_s, e_s;
    logic signed [9:0] dcol_s, drow_s;
    logic [COL_W-1:0]  dc_abs, dr_abs;
    logic              tri_right, tri_down;
    logic              line_ok, sq_ok, tri_ok, rd_ok, cmd_ok;

    // Per-row span
    logic [COL_W-1:0]  step, col0, ek, span_lo, span_hi;
    logic [ROW_AW-1:0] row_cur;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_width_reg  <= PANEL_RESET;
            panel_height_reg <= PANEL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PANEL_WIDTH:  panel_width_reg  <= pwdata[DIM_W-1:0];
                REG_PANEL_HEIGHT: panel_height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PANEL_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, panel_width_reg};
            REG_PANEL_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, panel_height_reg};
            default:          prdata = '0;
        endcase
    end

    assign w_eff = eff_dim(panel_width_reg, DIM_W'(MAX_COLS));
    assign h_eff = eff_dim(panel_height_reg, DIM_W'(MAX_ROWS));

    // ------------------------------------------------------------------
    // Range checks on the captured word
    // ------------------------------------------------------------------
    always_comb begin
        ac_s   = {{2{ac_reg[7]}}, ac_reg};
        ar_s   = {{2{ar_reg[7]}}, ar_reg};
        bc_s   = {{2{bc_reg[7]}}, bc_reg};
        br_s   = {{2{br_reg[7]}}, br_reg};
        w_s    = {3'b000, w_eff};
        h_s    = {3'b000, h_eff};
        side_s = {3'b000, side_reg};
        e_s    = side_s - 10'sd1;
        dcol_s = bc_s - ac_s;
        drow_s = br_s - ar_s;
        dc_abs = dcol_s[9] ? COL_W'(-dcol_s) : dcol_s[COL_W-1:0];
        dr_abs = drow_s[9] ? COL_W'(-drow_s) : drow_s[COL_W-1:0];

        tri_right = (dir_reg == DIR_RU) || (dir_reg == DIR_RD);
        tri_down  = (dir_reg == DIR_RD) || (dir_reg == DIR_LD);

        line_ok = (ac_s >= 0) && (ac_s < w_s) && (bc_s >= 0) && (bc_s < w_s) &&
                  (ar_s >= 0) && (ar_s < h_s) && (br_s >= 0) && (br_s < h_s);
        sq_ok   = (side_reg != '0) && (ac_s >= 0) && (ar_s >= 0) &&
                  (ac_s + e_s < w_s) && (ar_s + e_s < h_s);
        tri_ok  = (side_reg != '0) && (ac_s >= 0) && (ar_s >= 0) &&
                  (ac_s < w_s) && (ar_s < h_s) &&
                  (tri_right ? (ac_s + e_s < w_s) : (ac_s - e_s >= 0)) &&
                  (tri_down  ? (ar_s + e_s < h_s) : (ar_s - e_s >= 0));
        rd_ok   = (ar_s >= 0) && (ar_s < h_s);

        unique case (func_reg)
            FUNC_LINE:     cmd_ok = line_ok;
            FUNC_SQUARE:   cmd_ok = sq_ok;
            FUNC_TRIANGLE: cmd_ok = tri_ok;
            FUNC_READ:     cmd_ok = rd_ok;
            default:       cmd_ok = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Column span of the current row
    // ------------------------------------------------------------------
    always_comb begin
        step    = (k_reg < dc_reg) ? k_reg : dc_reg;
        col0    = col_neg_reg ? (col_a_reg - step) : (col_a_reg + step);
        ek      = e_reg - k_reg;
        row_cur = row_down_reg ? (row_start_reg + k_reg) : (row_start_reg - k_reg);
        span_lo = col_a_reg;
        span_hi = col_a_reg;
        unique case (func_reg)
            FUNC_LINE: begin
                // last row of a line holds the remaining horizontal run
                if (k_reg == last_k_reg) begin
                    span_lo = (col0 < col_b_reg) ? col0 : col_b_reg;
                    span_hi = (col0 < col_b_reg) ? col_b_reg : col0;
                end else begin
                    span_lo = col0;
                    span_hi = col0;
                end
            end
            FUNC_SQUARE: begin
                span_lo = col_a_reg;
                span_hi = col_a_reg + e_reg;
            end
            FUNC_TRIANGLE: begin
                span_lo = tri_right_reg ? col_a_reg : (col_a_reg - ek);
                span_hi = tri_right_reg ? (col_a_reg + ek) : col_a_reg;
            end
            FUNC_READ: begin
                span_lo = col_a_reg;
                span_hi = col_a_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) begin
                          state_next = ST_PREP;
                      end
            ST_PREP: begin
                priority if (!cmd_ok) begin
                    state_next = ST_DONE;
                end else if (func_reg == FUNC_READ) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:   if (k_reg == last_k_reg) begin
                          state_next = ST_DRAIN;
                      end
            ST_DRAIN: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_ready) begin
                          state_next = ST_IDLE;
                      end
            default:  state_next = ST_IDLE;
        endcase
    end

    // State machine: outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        rd_en    = (state_reg == ST_PREP) || (state_reg == ST_RUN);
        rd_addr  = (state_reg == ST_PREP) ? ar_reg[ROW_AW-1:0] : row_cur;
        load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            wr_en_reg     <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            wr_en_reg <= (state_reg == ST_RUN);
            if (wr_en_reg) begin
                row_valid_reg[wr_row_reg] <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command capture and run setup
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            ac_reg   <= s_point_a_col;
            ar_reg   <= s_point_a_row;
            bc_reg   <= s_point_b_col;
            br_reg   <= s_point_b_row;
            side_reg <= s_side_length;
            dir_reg  <= s_direction;
        end

        unique case (state_reg)
            ST_PREP: begin
                res_oor_reg   <= !cmd_ok;
                res_bits_reg  <= '0;
                k_reg         <= '0;
                col_a_reg     <= ac_reg[COL_W-1:0];
                col_b_reg     <= bc_reg[COL_W-1:0];
                col_neg_reg   <= (bc_s < ac_s);
                dc_reg        <= dc_abs;
                e_reg         <= e_s[COL_W-1:0];
                tri_right_reg <= tri_right;
                row_start_reg <= ar_reg[ROW_AW-1:0];
                unique case (func_reg)
                    FUNC_LINE: begin
                        row_down_reg <= (br_s >= ar_s);
                        last_k_reg   <= dr_abs;
                    end
                    FUNC_TRIANGLE: begin
                        row_down_reg <= tri_down;
                        last_k_reg   <= e_s[ROW_AW-1:0];
                    end
                    default: begin
                        row_down_reg <= 1'b1;
                        last_k_reg   <= e_s[ROW_AW-1:0];
                    end
                endcase
            end
            ST_RUN: begin
                k_reg       <= k_reg + ROW_AW'(1);
                wr_row_reg  <= row_cur;
                wr_mask_reg <= span_mask(span_lo, span_hi);
            end
            ST_READ: begin
                res_bits_reg <= rd_row_data &
                                span_mask('0, COL_W'(w_eff - DIM_W'(1)));
            end
            default: ;
        endcase

        if (load_out) begin
            m_oor_reg  <= res_oor_reg;
            m_bits_reg <= res_bits_reg;
        end
    end

    // ------------------------------------------------------------------
    // Row memory: registered read, masked write-back in the next cycle, not later
    // ------------------------------------------------------------------
    assign rd_row_data = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= pixel_mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (wr_en_reg) begin
            pixel_mem[wr_row_reg] <= rd_row_data | wr_mask_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_of_range = m_oor_reg;
    assign m_row_bits     = m_bits_reg;

endmodule

`default_nettype wire

@@ sv/bsre_checker.sv @@
// ---------------------------------------------------------------------------
// bsre_checker
// Port-level checks for the bitmap shape raster engine, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsre_checker
    import bsre_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic                m_out_of_range,
    input wire logic [MAX_COLS-1:0] m_row_bits
);

    // Result word holds while stalled
    a_out_hold: assert property (@(posedge aclk)
        aresetn && m_valid && !m_ready |=>
            m_valid && $stable(m_row_bits) && $stable(m_out_of_range))
        else $error("result word changed while stalled");

    // A rejected command never carries row data
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> (m_row_bits == '0))
        else $error("out_of_range result with nonzero row bits");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // One command at a time: busy right after accepting
    a_busy_after_accept: assert property (@(posedge aclk)
        aresetn && s_valid && s_ready |=> !s_ready)
        else $error("command accepted while previous still in flight");

endmodule

bind bitmap_shape_raster_engine_unit bsre_checker u_bsre_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_of_range (m_out_of_range),
    .m_row_bits     (m_row_bits)
);

`default_nettype wire
